### hw/rtl/wtpb_pkg.sv
// Shared types and constants for the weighted two-pixel blend pipeline.
package wtpb_pkg;

    localparam int unsigned CHAN_W         = 8;
    localparam int unsigned NUM_CHAN       = 3;
    localparam int unsigned PIX_W          = 32;
    localparam int unsigned WEIGHT_W       = 8;
    localparam int unsigned SUM_W          = WEIGHT_W + 1;
    localparam int unsigned PROD_W         = CHAN_W + WEIGHT_W;
    localparam int unsigned NUM_W          = PROD_W + 1;
    localparam int unsigned BITS_PER_STAGE = 2;
    localparam int unsigned DIV_STAGES     = CHAN_W / BITS_PER_STAGE;
    localparam int unsigned PIPE_DEPTH     = DIV_STAGES + 1;
    localparam int unsigned CFG_IDX_W      = 1;

    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_FIRST  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_SECOND = 1'b1;

    // Channel 0 is red, 1 is green and 2 is blue.
    typedef struct packed {
        logic [PIX_W-1:0]                 pix_first;
        logic                             zero;
        logic [NUM_CHAN-1:0][NUM_W-1:0]   rem;
        logic [NUM_CHAN-1:0][CHAN_W-1:0]  quo;
    } t_pipe;

endpackage

### hw/rtl/wtpb_mul_stage.sv
// Weighting stage: forms the weighted channel sums of the two pixels.
module wtpb_mul_stage
    import wtpb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_ld,
    input  logic                  i_valid,
    input  logic [PIX_W-1:0]      i_pixel_first,
    input  logic [PIX_W-1:0]      i_pixel_second,
    input  logic [WEIGHT_W-1:0]   i_weight_first,
    input  logic [WEIGHT_W-1:0]   i_weight_second,
    output logic                  o_valid,
    output t_pipe                 o_data
);

    logic  r_valid;
    t_pipe r_data;
    t_pipe n_data;
    logic [PROD_W-1:0] w_prod_a [NUM_CHAN];
    logic [PROD_W-1:0] w_prod_b [NUM_CHAN];

    always_comb begin
        n_data           = '0;
        n_data.pix_first = i_pixel_first;
        n_data.zero      = (i_weight_first == '0) && (i_weight_second == '0);
        for (int c = 0; c < NUM_CHAN; c++) begin
            w_prod_a[c] = i_pixel_first[CHAN_W*(NUM_CHAN-1-c) +: CHAN_W] * i_weight_first;
            w_prod_b[c] = i_pixel_second[CHAN_W*(NUM_CHAN-1-c) +: CHAN_W] * i_weight_second;
            n_data.rem[c] = NUM_W'(w_prod_a[c]) + NUM_W'(w_prod_b[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ld) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### hw/rtl/wtpb_div_stage.sv
// Restoring divider stage: resolves two quotient bits of each channel.
module wtpb_div_stage
    import wtpb_pkg::*;
#(
    parameter int unsigned QBIT_HI = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_ld,
    input  logic              i_valid,
    input  t_pipe             i_data,
    input  logic [SUM_W-1:0]  i_sum,
    output logic              o_valid,
    output t_pipe             o_data
);

    logic  r_valid;
    t_pipe r_data;
    t_pipe n_data;
    logic [NUM_W-1:0] w_div;

    always_comb begin
        n_data = i_data;
        w_div  = '0;
        for (int c = 0; c < NUM_CHAN; c++) begin
            for (int k = 0; k < BITS_PER_STAGE; k++) begin
                w_div = NUM_W'(i_sum) << (QBIT_HI - k);
                if (n_data.rem[c] >= w_div) begin
                    n_data.rem[c]               = n_data.rem[c] - w_div;
                    n_data.quo[c][QBIT_HI - k]  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ld) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### hw/rtl/weighted_two_pixel_blend_core.sv
// Top level of the weighted two-pixel blend core with its weight registers.
// The core takes one pixel pair per clock while any stage is empty or the output
// is ready, and returns blended pixels in order: the weighting stage forms the
// weighted sums and four restoring divider stages, two quotient bits each, divide
// by the weight sum. Each stage holds its transaction only while the one after it
// is full and stalled, so bubbles close up. Weights must be written through the
// configuration port only while the core is idle; the core does not enforce this.
module weighted_two_pixel_blend_core
    import wtpb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [WEIGHT_W-1:0]   i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // Bits 31-0 pixel_first, bits 63-32 pixel_second.
    input  logic [2*PIX_W-1:0]    s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // Bits 31-0 pixel_blended.
    output logic [PIX_W-1:0]      m_axis_tdata,
    // Bit 0 weights_zero.
    output logic                  m_axis_tuser
);

    logic [WEIGHT_W-1:0] r_weight_first;
    logic [WEIGHT_W-1:0] r_weight_second;
    logic [SUM_W-1:0]    w_sum;
    logic [PIPE_DEPTH:0] w_ld;
    logic                w_valid [PIPE_DEPTH];
    t_pipe               w_data  [PIPE_DEPTH];
    t_pipe               w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight_first  <= WEIGHT_W'(1);
            r_weight_second <= WEIGHT_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WEIGHT_FIRST:  r_weight_first  <= i_cfg_data;
                REG_WEIGHT_SECOND: r_weight_second <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_sum = SUM_W'(r_weight_first) + SUM_W'(r_weight_second);

    always_comb begin
        w_ld[PIPE_DEPTH] = m_axis_tready;
        for (int k = PIPE_DEPTH - 1; k >= 0; k--) begin
            w_ld[k] = !w_valid[k] || w_ld[k+1];
        end
    end

    assign s_axis_tready = w_ld[0];

    wtpb_mul_stage u_mul (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ld            (w_ld[0]),
        .i_valid         (s_axis_tvalid),
        .i_pixel_first   (s_axis_tdata[PIX_W-1:0]),
        .i_pixel_second  (s_axis_tdata[2*PIX_W-1:PIX_W]),
        .i_weight_first  (r_weight_first),
        .i_weight_second (r_weight_second),
        .o_valid         (w_valid[0]),
        .o_data          (w_data[0])
    );

    for (genvar g = 1; g < PIPE_DEPTH; g++) begin : g_div
        wtpb_div_stage #(
            .QBIT_HI (CHAN_W - 1 - BITS_PER_STAGE * (g - 1))
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ld    (w_ld[g]),
            .i_valid (w_valid[g-1]),
            .i_data  (w_data[g-1]),
            .i_sum   (w_sum),
            .o_valid (w_valid[g]),
            .o_data  (w_data[g])
        );
    end

    assign w_last        = w_data[PIPE_DEPTH-1];
    assign m_axis_tvalid = w_valid[PIPE_DEPTH-1];
    assign m_axis_tuser  = w_last.zero;
    assign m_axis_tdata  = w_last.zero ? w_last.pix_first
                         : {w_last.pix_first[PIX_W-1 -: CHAN_W],
                            w_last.quo[0], w_last.quo[1], w_last.quo[2]};

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("Input not ready although the output stage is empty.");

    a_ready_low_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("Input stalled without a stalled output.");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> w_valid[0])
        else $error("Accepted transaction did not enter the first stage.");

    a_stall_keeps_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid[PIPE_DEPTH-2] && !w_ld[PIPE_DEPTH-1]) |=> w_valid[PIPE_DEPTH-2])
        else $error("A stalled transaction was dropped before the output stage.");

endmodule

### tb/sv/weighted_two_pixel_blend_checker.sv
`timescale 1ns / 1ps
// Watches the weight port and both streams of the blend core, predicts and compares results.
module weighted_two_pixel_blend_checker
    import wtpb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [WEIGHT_W-1:0]   i_cfg_data,
    input  logic                  i_pair_valid,
    input  logic                  i_pair_ready,
    input  logic [2*PIX_W-1:0]    i_pair_data,
    input  logic                  i_blend_valid,
    input  logic                  i_blend_ready,
    input  logic [PIX_W-1:0]      i_blend_data,
    input  logic                  i_blend_zero,
    output int                    o_pending,
    output int                    o_errors
);

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             zero;
    } t_blend;

    t_blend               expected_blends[$];
    logic [WEIGHT_W-1:0]  weight_first;
    logic [WEIGHT_W-1:0]  weight_second;
    int                   mismatches = 0;

    function automatic t_blend blend_pixels(input logic [PIX_W-1:0] pix_a,
                                            input logic [PIX_W-1:0] pix_b,
                                            input logic [WEIGHT_W-1:0] wa,
                                            input logic [WEIGHT_W-1:0] wb);
        t_blend            res;
        logic [SUM_W-1:0]  sum;
        logic [NUM_W-1:0]  num;
        sum       = SUM_W'(wa) + SUM_W'(wb);
        res.pixel = pix_a;
        res.zero  = (sum == '0);
        if (!res.zero) begin
            for (int ch = 0; ch < NUM_CHAN; ch++) begin
                num = pix_a[CHAN_W*ch +: CHAN_W] * wa + pix_b[CHAN_W*ch +: CHAN_W] * wb;
                res.pixel[CHAN_W*ch +: CHAN_W] = CHAN_W'(num / NUM_W'(sum));
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_blend want;
        if (!i_rst_n) begin
            weight_first  = WEIGHT_W'(1);
            weight_second = WEIGHT_W'(1);
            expected_blends.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_WEIGHT_FIRST:  weight_first  = i_cfg_data;
                    REG_WEIGHT_SECOND: weight_second = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_pair_valid && i_pair_ready) begin
                expected_blends.push_back(blend_pixels(i_pair_data[PIX_W-1:0],
                                                       i_pair_data[2*PIX_W-1:PIX_W],
                                                       weight_first, weight_second));
            end
            if (i_blend_valid && i_blend_ready) begin
                if (expected_blends.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected transaction: pixel %h zero %b", i_blend_data,
                                 i_blend_zero);
                end else begin
                    want = expected_blends.pop_front();
                    if (want.pixel !== i_blend_data || want.zero !== i_blend_zero) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: expected pixel %h zero %b, got pixel %h zero %b",
                                     want.pixel, want.zero, i_blend_data, i_blend_zero);
                    end
                end
            end
        end
        o_pending <= expected_blends.size();
        o_errors  <= mismatches;
    end

endmodule

### tb/sv/weighted_two_pixel_blend_core_test.sv
`timescale 1ns / 1ps
// Top of the blend core testbench: clock, reset, weight writes, pixel stimulus and the verdict.
module weighted_two_pixel_blend_core_test;
    import wtpb_pkg::*;

    localparam int NUM_PHASES  = 9;
    localparam int PHASE_PAIRS = 100;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [WEIGHT_W-1:0]   i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [2*PIX_W-1:0]    s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [PIX_W-1:0]      m_axis_tdata;
    logic                  m_axis_tuser;

    int  pending;
    int  errors;
    bit  gaps_on = 1'b1;
    int  pairs_sent = 0;
    int  settings_used = 1;

    weighted_two_pixel_blend_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    weighted_two_pixel_blend_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_pair_valid  (s_axis_tvalid),
        .i_pair_ready  (s_axis_tready),
        .i_pair_data   (s_axis_tdata),
        .i_blend_valid (m_axis_tvalid),
        .i_blend_ready (m_axis_tready),
        .i_blend_data  (m_axis_tdata),
        .i_blend_zero  (m_axis_tuser),
        .o_pending     (pending),
        .o_errors      (errors)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Run timed out with %0d transactions outstanding.", pending);
        $display("[weighted_two_pixel_blend_core] ERROR");
        $finish;
    end

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            m_axis_tready <= !gaps_on || ($urandom_range(99) >= 7);
        end
    end

    task automatic set_weights(input logic [WEIGHT_W-1:0] wa, input logic [WEIGHT_W-1:0] wb);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_WEIGHT_FIRST;
        i_cfg_data <= wa;
        @(negedge i_clk);
        i_cfg_idx  <= REG_WEIGHT_SECOND;
        i_cfg_data <= wb;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        settings_used++;
    endtask

    task automatic send_pair(input logic [PIX_W-1:0] pix_a, input logic [PIX_W-1:0] pix_b);
        while (gaps_on && $urandom_range(99) < 7) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pix_b, pix_a};
        do @(posedge i_clk); while (!s_axis_tready);
        pairs_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (PIPE_DEPTH + 2) @(negedge i_clk);
    endtask

    function automatic logic [PIX_W-1:0] random_pixel();
        logic [PIX_W-1:0] pix;
        pix = $urandom;
        if ($urandom_range(7) == 0) begin
            for (int b = 0; b < PIX_W / CHAN_W; b++)
                pix[CHAN_W*b +: CHAN_W] = $urandom_range(1) ? 8'hff : 8'h00;
        end
        return pix;
    endfunction

    initial begin
        logic [PIX_W-1:0]     dir_first[6];
        logic [PIX_W-1:0]     dir_second[6];
        logic [WEIGHT_W-1:0]  phase_wa[NUM_PHASES];
        logic [WEIGHT_W-1:0]  phase_wb[NUM_PHASES];
        dir_first  = '{32'h0000_0000, 32'hffff_ffff, 32'hffff_ffff, 32'h0000_0000,
                       32'haa55_aa55, 32'h12fe_0180};
        dir_second = '{32'h0000_0000, 32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff,
                       32'h55aa_55aa, 32'hed01_ff7f};
        phase_wa   = '{8'd255, 8'd0, 8'd255, 8'd1, 8'd0, 8'd200, 8'd0, 8'd0, 8'd0};
        phase_wb   = '{8'd255, 8'd0, 8'd1, 8'd255, 8'd7, 8'd0, 8'd0, 8'd0, 8'd0};
        for (int p = 6; p < NUM_PHASES; p++) begin
            phase_wa[p] = WEIGHT_W'($urandom_range(255));
            phase_wb[p] = WEIGHT_W'($urandom_range(255));
        end

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = REG_WEIGHT_FIRST;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Extremes under the weights left by reset.
        for (int i = 0; i < 6; i++) send_pair(dir_first[i], dir_second[i]);
        wait_idle();
        // Both weights zero: the first pixel must pass unchanged with the flag raised.
        set_weights(8'd0, 8'd0);
        send_pair(32'h8040_20ff, 32'h0000_0000);
        send_pair(32'hffff_ffff, 32'h1234_5678);
        wait_idle();
        set_weights(8'd255, 8'd255);
        for (int i = 1; i < 4; i++) send_pair(dir_first[i], dir_second[i]);
        wait_idle();
        set_weights(8'd255, 8'd0);
        for (int i = 1; i < 4; i++) send_pair(dir_first[i], dir_second[i]);
        wait_idle();
        set_weights(8'd0, 8'd255);
        for (int i = 1; i < 4; i++) send_pair(dir_first[i], dir_second[i]);

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            set_weights(phase_wa[p], phase_wb[p]);
            gaps_on = (p != 3);
            for (int i = 0; i < PHASE_PAIRS; i++) begin
                send_pair(random_pixel(), random_pixel());
                if (p == 5 && i == PHASE_PAIRS / 2) wait_idle();
            end
        end
        gaps_on = 1'b1;
        wait_idle();

        $display("Covered %0d pixel pairs over %0d weight settings, zero and full-scale weights",
                 pairs_sent, settings_used);
        $display("included, with random stalls on both streams and one stall-free stretch.");
        if (errors == 0) begin
            $display("[weighted_two_pixel_blend_core] OK");
        end else begin
            $display("%0d mismatching transactions.", errors);
            $display("[weighted_two_pixel_blend_core] ERROR");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/wtpb_pkg.sv
hw/rtl/wtpb_mul_stage.sv
hw/rtl/wtpb_div_stage.sv
hw/rtl/weighted_two_pixel_blend_core.sv
tb/sv/weighted_two_pixel_blend_checker.sv
tb/sv/weighted_two_pixel_blend_core_test.sv
